// ===== rtl/v3n_pkg.sv =====
// Types and constants shared by the vector normalise pipeline.
// No dependencies.
package v3n_pkg;

   localparam int unsigned RootCells = 32;   // one root digit per cell
   localparam int unsigned DivCells  = 31;   // quotient bits 30 down to 0
   localparam int unsigned Lanes     = 3;

   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] unit_x;
      logic signed [31:0] unit_y;
      logic signed [31:0] unit_z;
      logic        [31:0] length;
      logic               is_zero;
   } rsp_type;

   // per-item context carried alongside the arithmetic
   typedef struct packed {
      logic [Lanes-1:0][31:0] mag;
      logic [Lanes-1:0]       neg;
      logic                   zero;
   } ctx_type;

   typedef struct packed {
      logic [63:0] sq;     // radicand, consumed two bits per cell
      logic [33:0] rem;
      logic [31:0] root;
   } root_type;

   typedef struct packed {
      logic [31:0]            len;
      logic [Lanes-1:0][32:0] rem;
      logic [Lanes-1:0][30:0] quo;
   } div_type;

endpackage

// ===== rtl/v3n_root_cell.sv =====
// One digit cell of the square root chain: settles one root bit per transfer.
// Depends on v3n_pkg.
module v3n_root_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  v3n_pkg::ctx_type  in_ctx,
   input  v3n_pkg::root_type in_work,
   output logic              out_valid,
   output v3n_pkg::ctx_type  out_ctx,
   output v3n_pkg::root_type out_work
);
   import v3n_pkg::*;

   logic     valid_ff;
   ctx_type  ctx_ff;
   root_type work_ff, work_in;
   logic [35:0] rem_sh, trial;
   logic        ge;

   always_comb begin
      rem_sh = {in_work.rem, in_work.sq[63:62]};
      trial  = {2'b00, in_work.root, 2'b01};
      ge     = (rem_sh >= trial);
      work_in.sq   = {in_work.sq[61:0], 2'b00};
      work_in.rem  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      work_in.root = {in_work.root[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctx_ff  <= in_ctx;
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;
   assign out_work  = work_ff;

endmodule

// ===== rtl/v3n_div_cell.sv =====
// One quotient bit cell of the divide chain, three lanes sharing the divisor.
// Depends on v3n_pkg.
module v3n_div_cell #(
   parameter bit FirstCell = 1'b0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  v3n_pkg::ctx_type in_ctx,
   input  v3n_pkg::div_type in_work,
   output logic             out_valid,
   output v3n_pkg::ctx_type out_ctx,
   output v3n_pkg::div_type out_work
);
   import v3n_pkg::*;

   logic    valid_ff;
   ctx_type ctx_ff;
   div_type work_ff, work_in;
   logic [Lanes-1:0][33:0] rem_sh;
   logic [Lanes-1:0]       ge;

   always_comb begin
      work_in.len = in_work.len;
      for (int i = 0; i < Lanes; i++) begin
         // the first cell tests the integer bit, so no shift there
         rem_sh[i] = FirstCell ? {1'b0, in_work.rem[i]} : {in_work.rem[i], 1'b0};
         ge[i]     = (rem_sh[i] >= {2'b00, in_work.len});
         work_in.rem[i] = ge[i] ? 33'(rem_sh[i] - {2'b00, in_work.len})
                                : rem_sh[i][32:0];
         work_in.quo[i] = {in_work.quo[i][29:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctx_ff  <= in_ctx;
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;
   assign out_work  = work_ff;

endmodule

// ===== rtl/vector3_normalize.sv =====
// Three-component vector normalise: Q16.16 in, Q2.30 unit vector and length out.
// Depends on v3n_pkg, v3n_root_cell and v3n_div_cell.
//
// Input channel req_: req_valid with req_data (x, y, z); a transfer happens when
// req_valid is high and req_stall is low. Result channel rsp_: rsp_valid with
// rsp_data (unit components, length, zero flag), taken when rsp_stall is low.
// One result per input, in order.
// Throughput: one vector per cycle while rsp_stall does not hold the pipeline. The
// pipeline is abs, square, sum, 32 square-root digit cells, 31 divide cells and the
// output register.
// Every stage moves together; while a result sits in the output register and
// rsp_stall is high the whole pipeline holds and req_stall is raised. Items in
// flight are kept, never dropped.
// Reset (synchronous, active high) empties the pipeline; nothing else is
// stored, so the block is ready in the cycle after reset falls.
// A zero vector gives zero components, zero length and is_zero set.
module vector3_normalize (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  v3n_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output v3n_pkg::rsp_type rsp_data
);
   import v3n_pkg::*;

   logic advance;

   logic                   s1_valid_ff;
   logic [Lanes-1:0][31:0] s1_mag_ff;
   logic [Lanes-1:0]       s1_neg_ff;
   logic [Lanes-1:0][31:0] s1_mag_in;
   logic [Lanes-1:0]       s1_neg_in;

   logic                   s2_valid_ff;
   ctx_type                s2_ctx_ff;
   logic [Lanes-1:0][63:0] s2_sq_ff;

   logic                   s3_valid_ff;
   ctx_type                s3_ctx_ff;
   logic [63:0]            s3_sum_ff;
   logic [63:0]            s3_sum_in;

   logic     [RootCells:0] rt_valid;
   ctx_type  [RootCells:0] rt_ctx;
   root_type [RootCells:0] rt_work;

   logic     [DivCells:0]  dv_valid;
   ctx_type  [DivCells:0]  dv_ctx;
   div_type  [DivCells:0]  dv_work;

   logic    out_valid_ff;
   rsp_type out_data_ff, out_data_in;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      s1_neg_in[0] = req_data.vec_x[31];
      s1_neg_in[1] = req_data.vec_y[31];
      s1_neg_in[2] = req_data.vec_z[31];
      s1_mag_in[0] = req_data.vec_x[31] ? 32'(-req_data.vec_x) : req_data.vec_x;
      s1_mag_in[1] = req_data.vec_y[31] ? 32'(-req_data.vec_y) : req_data.vec_y;
      s1_mag_in[2] = req_data.vec_z[31] ? 32'(-req_data.vec_z) : req_data.vec_z;
      s3_sum_in    = s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mag_ff <= s1_mag_in;
         s1_neg_ff <= s1_neg_in;
         s2_ctx_ff <= '{mag: s1_mag_ff, neg: s1_neg_ff, zero: 1'b0};
         for (int i = 0; i < Lanes; i++) begin
            s2_sq_ff[i] <= s1_mag_ff[i] * s1_mag_ff[i];
         end
         s3_ctx_ff <= '{mag: s2_ctx_ff.mag, neg: s2_ctx_ff.neg,
                        zero: (s3_sum_in == 64'd0)};
         s3_sum_ff <= s3_sum_in;
      end
   end

   // square root chain
   assign rt_valid[0]     = s3_valid_ff;
   assign rt_ctx[0]       = s3_ctx_ff;
   assign rt_work[0].sq   = s3_sum_ff;
   assign rt_work[0].rem  = '0;
   assign rt_work[0].root = '0;

   for (genvar k = 0; k < RootCells; k++) begin : g_root
      v3n_root_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (rt_valid[k]),
         .in_ctx   (rt_ctx[k]),
         .in_work  (rt_work[k]),
         .out_valid(rt_valid[k+1]),
         .out_ctx  (rt_ctx[k+1]),
         .out_work (rt_work[k+1])
      );
   end

   // divide chain: remainder starts as the magnitude, which never exceeds the length
   assign dv_valid[0]    = rt_valid[RootCells];
   assign dv_ctx[0]      = rt_ctx[RootCells];
   assign dv_work[0].len = rt_work[RootCells].root;
   for (genvar l = 0; l < Lanes; l++) begin : g_lane
      assign dv_work[0].rem[l] = {1'b0, rt_ctx[RootCells].mag[l]};
      assign dv_work[0].quo[l] = '0;
   end

   for (genvar k = 0; k < DivCells; k++) begin : g_div
      v3n_div_cell #(
         .FirstCell(k == 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (dv_valid[k]),
         .in_ctx   (dv_ctx[k]),
         .in_work  (dv_work[k]),
         .out_valid(dv_valid[k+1]),
         .out_ctx  (dv_ctx[k+1]),
         .out_work (dv_work[k+1])
      );
   end

   always_comb begin
      logic [Lanes-1:0][31:0] unit;
      for (int i = 0; i < Lanes; i++) begin
         unit[i] = dv_ctx[DivCells].neg[i] ? 32'(-{1'b0, dv_work[DivCells].quo[i]})
                                           : {1'b0, dv_work[DivCells].quo[i]};
      end
      if (dv_ctx[DivCells].zero) begin
         out_data_in = '0;
         out_data_in.is_zero = 1'b1;
      end else begin
         out_data_in.unit_x  = unit[0];
         out_data_in.unit_y  = unit[1];
         out_data_in.unit_z  = unit[2];
         out_data_in.length  = dv_work[DivCells].len;
         out_data_in.is_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid[DivCells];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
